// ===== rtl/aqic_pkg.sv =====
package aqic_pkg;

  typedef enum logic [1:0] {
    SCHEME_ATMO = 2'd0,
    SCHEME_CAQI = 2'd1,
    SCHEME_US   = 2'd2
  } scheme_t;

  localparam logic [1:0] SCHEME_RESET = SCHEME_US;

  localparam logic [2:0] CAT_EXCELLENT  = 3'd0;
  localparam logic [2:0] CAT_GOOD       = 3'd1;
  localparam logic [2:0] CAT_ACCEPTABLE = 3'd2;
  localparam logic [2:0] CAT_MODERATE   = 3'd3;
  localparam logic [2:0] CAT_HEAVY      = 3'd4;
  localparam logic [2:0] CAT_SEVERE     = 3'd5;
  localparam logic [2:0] CAT_HAZARDOUS  = 3'd6;

  localparam logic [9:0] US_BEYOND = 10'd1001;
  localparam logic [9:0] CAQI_TOP  = 10'd150;

  // us breakpoints per pollutant and band; the last pm10 band is unused
  localparam logic [13:0] US_CLO [2][8] = '{
    '{14'd0, 14'd121, 14'd355, 14'd555, 14'd1505, 14'd2505, 14'd3505, 14'd5005},
    '{14'd0, 14'd541, 14'd1541, 14'd2541, 14'd3551, 14'd4251, 14'd5051, 14'd0}
  };
  localparam logic [13:0] US_CHI [2][8] = '{
    '{14'd120, 14'd354, 14'd554, 14'd1504, 14'd2504, 14'd3504, 14'd5004, 14'd10000},
    '{14'd540, 14'd1540, 14'd2540, 14'd3550, 14'd4250, 14'd5050, 14'd6050, 14'd0}
  };
  localparam logic [9:0] US_ILO [2][8] = '{
    '{10'd0, 10'd51, 10'd101, 10'd151, 10'd201, 10'd301, 10'd401, 10'd501},
    '{10'd0, 10'd51, 10'd101, 10'd151, 10'd201, 10'd301, 10'd401, 10'd0}
  };
  // index span of each band (ihigh - ilow)
  localparam logic [8:0] US_SPAN [2][8] = '{
    '{9'd50, 9'd49, 9'd49, 9'd49, 9'd99, 9'd99, 9'd99, 9'd499},
    '{9'd50, 9'd49, 9'd49, 9'd49, 9'd99, 9'd99, 9'd99, 9'd0}
  };
  // concentration span of each band (chigh - clow)
  localparam logic [12:0] US_DIV [2][8] = '{
    '{13'd120, 13'd233, 13'd199, 13'd949, 13'd999, 13'd999, 13'd1499, 13'd4995},
    '{13'd540, 13'd999, 13'd999, 13'd1009, 13'd699, 13'd799, 13'd999, 13'd0}
  };
  // floor(2^32 / span), never above the exact reciprocal
  localparam logic [25:0] US_RCP [2][8] = '{
    '{26'((33'd1 << 32) / 33'd120),  26'((33'd1 << 32) / 33'd233),
      26'((33'd1 << 32) / 33'd199),  26'((33'd1 << 32) / 33'd949),
      26'((33'd1 << 32) / 33'd999),  26'((33'd1 << 32) / 33'd999),
      26'((33'd1 << 32) / 33'd1499), 26'((33'd1 << 32) / 33'd4995)},
    '{26'((33'd1 << 32) / 33'd540),  26'((33'd1 << 32) / 33'd999),
      26'((33'd1 << 32) / 33'd999),  26'((33'd1 << 32) / 33'd1009),
      26'((33'd1 << 32) / 33'd699),  26'((33'd1 << 32) / 33'd799),
      26'((33'd1 << 32) / 33'd999),  26'd0}
  };

  localparam logic [9:0] ATMO_LIM [2][9] = '{
    '{10'd110, 10'd240, 10'd360, 10'd410, 10'd470, 10'd530, 10'd580, 10'd640, 10'd690},
    '{10'd60, 10'd130, 10'd200, 10'd270, 10'd340, 10'd410, 10'd490, 10'd640, 10'd790}
  };

  localparam logic [10:0] CAQI_LIM [2][4] = '{
    '{11'd150, 11'd300, 11'd550, 11'd1100},
    '{11'd250, 11'd500, 11'd900, 11'd1800}
  };
  localparam logic [9:0] CAQI_IDX [4] = '{10'd25, 10'd50, 10'd75, 10'd100};
  localparam logic [2:0] CAQI_CAT [4] = '{CAT_GOOD, CAT_ACCEPTABLE, CAT_MODERATE, CAT_HEAVY};

  // operands for the us interpolation of one reading
  typedef struct packed {
    logic        beyond;
    logic [9:0]  ilo;
    logic [8:0]  span;
    logic [12:0] dc;
    logic [12:0] div;
    logic [25:0] rcp;
  } us_term_t;

  // result of the table-only schemes, or a mark that the us path decides
  typedef struct packed {
    logic       use_us;
    logic [9:0] idx;
    logic [2:0] cat;
  } simple_res_t;

  function automatic logic [2:0] atmo_cat(input logic [3:0] band);
    logic [2:0] c;
    unique case (band)
      4'd3, 4'd4: c = CAT_GOOD;
      4'd5:       c = CAT_ACCEPTABLE;
      4'd6, 4'd7: c = CAT_MODERATE;
      4'd8, 4'd9: c = CAT_HEAVY;
      4'd10:      c = CAT_SEVERE;
      default:    c = CAT_EXCELLENT;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] us_cat(input logic [9:0] v);
    logic [2:0] c;
    priority if (v <= 10'd50)  c = CAT_GOOD;
    else if (v <= 10'd100)     c = CAT_ACCEPTABLE;
    else if (v <= 10'd150)     c = CAT_MODERATE;
    else if (v <= 10'd200)     c = CAT_HEAVY;
    else if (v <= 10'd300)     c = CAT_SEVERE;
    else                       c = CAT_HAZARDOUS;
    return c;
  endfunction

endpackage

// ===== rtl/aqic_band.sv =====
module aqic_band (
  input  logic                      pollutant,
  input  logic [15:0]               conc,
  input  logic [1:0]                scheme,
  output aqic_pkg::us_term_t        term,
  output aqic_pkg::simple_res_t     simple
);
  import aqic_pkg::*;

  logic       us_hit;
  logic [2:0] us_sel;
  logic [3:0] atmo_band;
  logic       caqi_hit;
  logic [1:0] caqi_sel;

  // first band whose upper breakpoint covers the reading
  always_comb begin
    us_hit = 1'b0;
    us_sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (US_CHI[pollutant][i] > US_CLO[pollutant][i] &&
          conc <= {2'b00, US_CHI[pollutant][i]}) begin
        us_hit = 1'b1;
        us_sel = 3'(i);
      end
    end
  end

  always_comb begin
    term.beyond = !us_hit;
    term.ilo    = US_ILO[pollutant][us_sel];
    term.span   = US_SPAN[pollutant][us_sel];
    term.dc     = 13'(conc - {2'b00, US_CLO[pollutant][us_sel]});
    term.div    = US_DIV[pollutant][us_sel];
    term.rcp    = US_RCP[pollutant][us_sel];
  end

  always_comb begin
    atmo_band = 4'd10;
    for (int i = 8; i >= 0; i--) begin
      if (conc <= {6'd0, ATMO_LIM[pollutant][i]}) atmo_band = 4'(i + 1);
    end
  end

  always_comb begin
    caqi_hit = 1'b0;
    caqi_sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (conc <= {5'd0, CAQI_LIM[pollutant][i]}) begin
        caqi_hit = 1'b1;
        caqi_sel = 2'(i);
      end
    end
  end

  always_comb begin
    simple.use_us = 1'b0;
    simple.idx    = 10'd0;
    simple.cat    = CAT_GOOD;
    if (scheme == SCHEME_ATMO) begin
      simple.idx = {6'd0, atmo_band};
      simple.cat = atmo_cat(atmo_band);
    end else if (scheme == SCHEME_CAQI) begin
      if (conc == 16'd0) begin
        simple.idx = 10'd0;
        simple.cat = CAT_GOOD;
      end else if (caqi_hit) begin
        simple.idx = CAQI_IDX[caqi_sel];
        simple.cat = CAQI_CAT[caqi_sel];
      end else begin
        simple.idx = CAQI_TOP;
        simple.cat = CAT_SEVERE;
      end
    end else begin
      // unused scheme code falls through to us as well
      simple.use_us = 1'b1;
    end
  end

endmodule

// ===== rtl/aqic_interp.sv =====
module aqic_interp (
  input  logic               clk,
  input  logic               en,
  input  aqic_pkg::us_term_t term,
  output logic [9:0]         index_value,
  output logic [2:0]         category
);
  import aqic_pkg::*;

  logic [21:0] num_c_r;
  logic [9:0]  ilo_c_r;
  logic [12:0] div_c_r;
  logic [25:0] rcp_c_r;
  logic        beyond_c_r;

  logic [21:0] num_d_r;
  logic [8:0]  qest_d_r;
  logic [9:0]  ilo_d_r;
  logic [12:0] div_d_r;
  logic        beyond_d_r;

  logic [21:0] num_c_nxt;
  logic [47:0] prod_d_nxt;
  logic [21:0] back_mul;
  logic [21:0] rem;
  logic [8:0]  quot;
  logic [9:0]  val;

  assign num_c_nxt  = 22'(term.span) * 22'(term.dc);
  assign prod_d_nxt = 48'(num_c_r) * 48'(rcp_c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      num_c_r    <= num_c_nxt;
      ilo_c_r    <= term.ilo;
      div_c_r    <= term.div;
      rcp_c_r    <= term.rcp;
      beyond_c_r <= term.beyond;
      num_d_r    <= num_c_r;
      qest_d_r   <= prod_d_nxt[40:32];
      ilo_d_r    <= ilo_c_r;
      div_d_r    <= div_c_r;
      beyond_d_r <= beyond_c_r;
    end
  end

  // reciprocal estimate is low by at most one
  assign back_mul = 22'(qest_d_r) * 22'(div_d_r);
  assign rem      = num_d_r - back_mul;
  assign quot     = qest_d_r + 9'((rem >= {9'd0, div_d_r}) ? 1 : 0);
  assign val      = ilo_d_r + {1'b0, quot};

  assign index_value = beyond_d_r ? US_BEYOND : val;
  assign category    = beyond_d_r ? CAT_HAZARDOUS : us_cat(val);

endmodule

// ===== rtl/air_quality_index_classifier.sv =====
// each reading passes through stage registers a, b, c and d and then the output register
// throughput: one reading per cycle while the output is not stalled; stages advance together with the output register
// a stall at the output holds every stage and drops in_ready in the same cycle
// reset (synchronous, active low) empties the pipeline and selects the us scheme
module air_quality_index_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pollutant,
  input  logic [15:0] in_concentration_tenths,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_index_value,
  output logic [2:0]  out_category,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_scheme
);
  import aqic_pkg::*;

  logic        adv;
  logic [1:0]  scheme_r;
  logic        va_r, vb_r, vc_r, vd_r, out_valid_r;

  logic        pol_a_r;
  logic [15:0] conc_a_r;
  us_term_t    term_b_nxt, term_b_r;
  simple_res_t simple_b_nxt, simple_b_r, simple_c_r, simple_d_r;
  logic [9:0]  us_idx;
  logic [2:0]  us_cat_val;
  logic [9:0]  out_idx_r;
  logic [2:0]  out_cat_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r    <= SCHEME_RESET;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) scheme_r <= cfg_index_scheme;
      if (adv) begin
        va_r        <= in_valid;
        vb_r        <= va_r;
        vc_r        <= vb_r;
        vd_r        <= vc_r;
        out_valid_r <= vd_r;
      end
    end
  end

  aqic_band u_band (
    .pollutant (pol_a_r),
    .conc      (conc_a_r),
    .scheme    (scheme_r),
    .term      (term_b_nxt),
    .simple    (simple_b_nxt)
  );

  aqic_interp u_interp (
    .clk         (clk),
    .en          (adv),
    .term        (term_b_r),
    .index_value (us_idx),
    .category    (us_cat_val)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pol_a_r    <= in_pollutant;
      conc_a_r   <= in_concentration_tenths;
      term_b_r   <= term_b_nxt;
      simple_b_r <= simple_b_nxt;
      simple_c_r <= simple_b_r;
      simple_d_r <= simple_c_r;
      out_idx_r  <= simple_d_r.use_us ? us_idx : simple_d_r.idx;
      out_cat_r  <= simple_d_r.use_us ? us_cat_val : simple_d_r.cat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index_value = out_idx_r;
  assign out_category    = out_cat_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> va_r)
    else $error("accepted beat did not enter the first stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_index_value <= US_BEYOND)
    else $error("index out of range");

  a_beyond_hazardous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_value == US_BEYOND |-> out_category == CAT_HAZARDOUS)
    else $error("beyond-table index with wrong category");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r && adv |=> out_valid_r)
    else $error("last stage did not reach the output register");

endmodule

// ===== tb/air_quality_index_classifier_test.sv =====
module air_quality_index_classifier_test;
  import aqic_pkg::*;

  typedef struct {
    int unsigned serial;
    logic        pollutant;
    logic [15:0] conc;
    logic [9:0]  index_value;
    logic [2:0]  category;
  } aqi_reading_t;

  class aqi_scoreboard;
    logic [1:0]   scheme;
    aqi_reading_t due_q[$];
    int unsigned  noted;
    int unsigned  checked;
    int unsigned  failures;
    int unsigned  us_lo[2][8], us_hi[2][8], ix_lo[2][8], ix_hi[2][8];
    int unsigned  atmo_lim[2][9];
    int unsigned  caqi_lim[2][4];
    logic [2:0]   caqi_cat[4];

    function new();
      scheme = SCHEME_RESET;
      us_lo = '{'{0, 121, 355, 555, 1505, 2505, 3505, 5005},
                '{0, 541, 1541, 2541, 3551, 4251, 5051, 0}};
      us_hi = '{'{120, 354, 554, 1504, 2504, 3504, 5004, 10000},
                '{540, 1540, 2540, 3550, 4250, 5050, 6050, 0}};
      ix_lo = '{'{0, 51, 101, 151, 201, 301, 401, 501},
                '{0, 51, 101, 151, 201, 301, 401, 0}};
      ix_hi = '{'{50, 100, 150, 200, 300, 400, 500, 1000},
                '{50, 100, 150, 200, 300, 400, 500, 0}};
      atmo_lim = '{'{110, 240, 360, 410, 470, 530, 580, 640, 690},
                   '{60, 130, 200, 270, 340, 410, 490, 640, 790}};
      caqi_lim = '{'{150, 300, 550, 1100}, '{250, 500, 900, 1800}};
      caqi_cat = '{CAT_GOOD, CAT_ACCEPTABLE, CAT_MODERATE, CAT_HEAVY};
    endfunction

    function void predict_index(input logic pol, input logic [15:0] conc,
                                output logic [9:0] idx, output logic [2:0] cat);
      int unsigned c, p, v;
      c = conc;
      p = pol;
      case (scheme)
        SCHEME_ATMO: begin
          v = 10;
          // descending scan leaves the lowest band whose limit holds
          for (int i = 8; i >= 0; i--) if (c <= atmo_lim[p][i]) v = i + 1;
          idx = 10'(v);
          if (v <= 2) cat = CAT_EXCELLENT;
          else if (v <= 4) cat = CAT_GOOD;
          else if (v == 5) cat = CAT_ACCEPTABLE;
          else if (v <= 7) cat = CAT_MODERATE;
          else if (v <= 9) cat = CAT_HEAVY;
          else cat = CAT_SEVERE;
        end
        SCHEME_CAQI: begin
          idx = CAQI_TOP;
          cat = CAT_SEVERE;
          for (int i = 3; i >= 0; i--) begin
            if (c <= caqi_lim[p][i]) begin
              idx = 10'(25 * (i + 1));
              cat = caqi_cat[i];
            end
          end
          if (c == 0) begin
            idx = '0;
            cat = CAT_GOOD;
          end
        end
        default: begin
          // us scheme, the spare code falls back to it as well
          v = US_BEYOND;
          if (c == 0) v = 0;
          else begin
            for (int i = 7; i >= 0; i--) begin
              if (us_hi[p][i] > us_lo[p][i] && c <= us_hi[p][i])
                v = ix_lo[p][i] + ((ix_hi[p][i] - ix_lo[p][i]) * (c - us_lo[p][i])) /
                    (us_hi[p][i] - us_lo[p][i]);
            end
          end
          idx = 10'(v);
          if (v <= 50) cat = CAT_GOOD;
          else if (v <= 100) cat = CAT_ACCEPTABLE;
          else if (v <= 150) cat = CAT_MODERATE;
          else if (v <= 200) cat = CAT_HEAVY;
          else if (v <= 300) cat = CAT_SEVERE;
          else cat = CAT_HAZARDOUS;
        end
      endcase
    endfunction

    function void note_reading(input logic pol, input logic [15:0] conc);
      aqi_reading_t r;
      r.serial = noted;
      r.pollutant = pol;
      r.conc = conc;
      predict_index(pol, conc, r.index_value, r.category);
      due_q.push_back(r);
      noted++;
    endfunction

    function void check_result(input logic [9:0] idx, input logic [2:0] cat);
      aqi_reading_t r;
      if (due_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result beat with nothing pending: index %0d category %0d", idx, cat);
        return;
      end
      r = due_q.pop_front();
      checked++;
      if (idx !== r.index_value || cat !== r.category) begin
        failures++;
        if (failures <= 10)
          $display("reading %0d (pm%s, %0d, scheme %0d): exp %0d/%0d got %0d/%0d",
                   r.serial, r.pollutant ? "10" : "2.5", r.conc, scheme,
                   r.index_value, r.category, idx, cat);
      end
    endfunction
  endclass

  localparam logic [1:0] SCHEME_SPARE = 2'd3;
  localparam logic [1:0] SCHEME_ORDER [4] = '{SCHEME_ATMO, SCHEME_CAQI, SCHEME_US, SCHEME_SPARE};
  localparam int unsigned CYCLE_LIMIT = 200000;
  // table breakpoints that random readings land near
  localparam int unsigned BREAK_PTS [24] = '{
    120, 354, 554, 1504, 2504, 3504, 5004, 10000, 540, 1540, 2540, 3550,
    4250, 5050, 6050, 110, 240, 360, 690, 60, 790, 150, 1100, 1800
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_pollutant = 1'b0;
  logic [15:0] in_concentration_tenths = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_index_value;
  logic [2:0]  out_category;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index_scheme = SCHEME_RESET;

  aqi_scoreboard sbd = new();

  int unsigned cycles = 0;
  int unsigned scheme_writes = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  air_quality_index_classifier i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_pollutant            (in_pollutant),
    .in_concentration_tenths (in_concentration_tenths),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_index_value         (out_index_value),
    .out_category            (out_category),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index_scheme        (cfg_index_scheme)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check each beat, stall at random or for a long hold
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sbd.check_result(out_index_value, out_category);
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_reading(input logic pol, input logic [15:0] conc);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_pollutant <= pol;
    in_concentration_tenths <= conc;
    do @(posedge clk); while (!in_ready);
    sbd.note_reading(pol, conc);
  endtask

  // drains the pipeline first so the scheme only changes while idle
  task automatic set_scheme(input logic [1:0] v);
    in_valid <= 1'b0;
    while (sbd.due_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index_scheme <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sbd.scheme = v;
    scheme_writes++;
  endtask

  initial begin
    int unsigned r, b;
    logic        pol;
    logic [15:0] conc;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 27;
    recv_idle_pct = 66;

    set_scheme(SCHEME_US);
    send_reading(1'b0, 16'd0);
    send_reading(1'b1, 16'd0);
    send_reading(1'b0, 16'd120);
    send_reading(1'b0, 16'd10000);
    send_reading(1'b0, 16'd10001);
    send_reading(1'b1, 16'd6050);
    send_reading(1'b1, 16'd6051);
    send_reading(1'b1, 16'hFFFF);
    set_scheme(SCHEME_ATMO);
    send_reading(1'b0, 16'd0);
    send_reading(1'b0, 16'd690);
    send_reading(1'b0, 16'd691);
    send_reading(1'b1, 16'd790);
    send_reading(1'b1, 16'd791);
    send_reading(1'b1, 16'hFFFF);
    set_scheme(SCHEME_CAQI);
    send_reading(1'b0, 16'd0);
    send_reading(1'b0, 16'd1);
    send_reading(1'b0, 16'd1100);
    send_reading(1'b0, 16'd1101);
    send_reading(1'b1, 16'd1800);
    send_reading(1'b1, 16'd1801);
    set_scheme(SCHEME_SPARE);
    send_reading(1'b0, 16'd5004);
    send_reading(1'b1, 16'd541);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 66 : 0;
      recv_idle_pct = (mode == 0) ? 66 : (mode == 1) ? 27 : 0;
      for (int k = 0; k < 4; k++) begin
        set_scheme(SCHEME_ORDER[k]);
        // long output stall with a steady sender backs the pipeline up
        if (mode == 2 && k == 0) hold_asks <= hold_asks + 1;
        for (int n = 0; n < 34; n++) begin
          pol = 1'($urandom_range(0, 1));
          r = $urandom_range(0, 9);
          if (r < 2) begin
            conc = 16'($urandom_range(0, 65535));
          end else if (r == 2) begin
            b = BREAK_PTS[$urandom_range(0, 23)];
            conc = 16'(b + $urandom_range(0, 2) - 1);
          end else if (r < 5) begin
            conc = 16'($urandom_range(0, 1000));
          end else begin
            conc = 16'($urandom_range(0, 10100));
          end
          send_reading(pol, conc);
        end
      end
    end

    in_valid <= 1'b0;
    while (sbd.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d readings over all four scheme codes and three stall mixes, %0d scheme writes",
             sbd.noted, scheme_writes);
    $display("%0d results checked, %0d failures", sbd.checked, sbd.failures);
    if (sbd.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aqic_pkg.sv
rtl/aqic_band.sv
rtl/aqic_interp.sv
rtl/air_quality_index_classifier.sv
tb/air_quality_index_classifier_test.sv
